// File: rtl/core/rrbt_pkg.sv
// ----------------------------------------------------------------------------
// rrbt_pkg
// Shared types and constants for the request retry backoff timer.
// ----------------------------------------------------------------------------
`default_nettype none

package rrbt_pkg;

  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ID_W     = 64;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned S_DATA_W = 72;
  localparam int unsigned M_DATA_W = 48;

  localparam logic [31:0] SHARD_INIT_RST  = 32'd250;
  localparam logic [31:0] SHARD_MAX_RST   = 32'd2000;
  localparam logic [31:0] SHARD_DL_RST    = 32'd10000;
  localparam logic [31:0] COORD_INIT_RST  = 32'd1000;
  localparam logic [31:0] COORD_MAX_RST   = 32'd10000;
  localparam logic [31:0] COORD_DL_RST    = 32'd120000;

  typedef enum logic [2:0] {
    REG_SHARD_INIT = 3'd0,
    REG_SHARD_MAX  = 3'd1,
    REG_SHARD_DL   = 3'd2,
    REG_COORD_INIT = 3'd3,
    REG_COORD_MAX  = 3'd4,
    REG_COORD_DL   = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_RESP  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    EV_NOTHING = 3'd0,
    EV_SEND    = 3'd1,
    EV_DONE    = 3'd2,
    EV_TIMEOUT = 3'd3,
    EV_NOADDR  = 3'd4,
    EV_DROPPED = 3'd5
  } event_t;

  typedef struct packed {
    logic [31:0] shard_initial_wait;
    logic [31:0] shard_max_wait;
    logic [31:0] shard_deadline;
    logic [31:0] coord_initial_wait;
    logic [31:0] coord_max_wait;
    logic [31:0] coord_deadline;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/core/rrbt_regs.sv
// ----------------------------------------------------------------------------
// rrbt_regs
// APB register file holding the wait, cap and deadline settings.
// ----------------------------------------------------------------------------
`default_nettype none

module rrbt_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rrbt_pkg::ADDR_W-1:0] paddr,
  input  wire logic [rrbt_pkg::DATA_W-1:0] pwdata,
  output logic      [rrbt_pkg::DATA_W-1:0] prdata,
  output logic                             pready,
  output rrbt_pkg::cfg_t                   cfg
);

  rrbt_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = rrbt_pkg::reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shard_initial_wait <= rrbt_pkg::SHARD_INIT_RST;
      cfg.shard_max_wait     <= rrbt_pkg::SHARD_MAX_RST;
      cfg.shard_deadline     <= rrbt_pkg::SHARD_DL_RST;
      cfg.coord_initial_wait <= rrbt_pkg::COORD_INIT_RST;
      cfg.coord_max_wait     <= rrbt_pkg::COORD_MAX_RST;
      cfg.coord_deadline     <= rrbt_pkg::COORD_DL_RST;
    end else if (wr_en) begin
      case (idx)
        rrbt_pkg::REG_SHARD_INIT: cfg.shard_initial_wait <= pwdata;
        rrbt_pkg::REG_SHARD_MAX:  cfg.shard_max_wait     <= pwdata;
        rrbt_pkg::REG_SHARD_DL:   cfg.shard_deadline     <= pwdata;
        rrbt_pkg::REG_COORD_INIT: cfg.coord_initial_wait <= pwdata;
        rrbt_pkg::REG_COORD_MAX:  cfg.coord_max_wait     <= pwdata;
        rrbt_pkg::REG_COORD_DL:   cfg.coord_deadline     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rrbt_pkg::REG_SHARD_INIT: prdata = cfg.shard_initial_wait;
      rrbt_pkg::REG_SHARD_MAX:  prdata = cfg.shard_max_wait;
      rrbt_pkg::REG_SHARD_DL:   prdata = cfg.shard_deadline;
      rrbt_pkg::REG_COORD_INIT: prdata = cfg.coord_initial_wait;
      rrbt_pkg::REG_COORD_MAX:  prdata = cfg.coord_max_wait;
      rrbt_pkg::REG_COORD_DL:   prdata = cfg.coord_deadline;
      default:                  prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/request_retry_backoff_timer_top.sv
// ----------------------------------------------------------------------------
// request_retry_backoff_timer_top
// Retransmission timer with exponential backoff for one outstanding request.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  tuser: cmd; tdata: id, coord, prim_ok, sec_ok
//   m_*      out  m_tvalid/m_tready  tuser: event; tdata: addr idx, attempts, ticks
//   apb      in   psel/penable       six 32-bit settings at 4*index
//
// One request per cycle sustained unless m_tready stalls the result register;
// each request passes through the input register, then the result register.
// Request state updates in the same cycle the result register loads.
// Reset is synchronous and returns settings and state to their defaults.
// A stalled m_tready holds the result; the input register still takes one request.
// ----------------------------------------------------------------------------
`default_nettype none

module request_retry_backoff_timer_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // APB
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rrbt_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [rrbt_pkg::DATA_W-1:0]   pwdata,
  output logic      [rrbt_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  // request stream
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // [63:0] txn_id, [64] to_coordinator, [65] primary_addr_ok,
  // [66] secondary_addr_ok, [71:67] zero
  input  wire logic [rrbt_pkg::S_DATA_W-1:0] s_tdata,
  // [1:0] cmd
  input  wire logic [1:0]                    s_tuser,
  // result stream
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // [0] send_addr_index, [8:1] attempt_count, [40:9] elapsed_ticks, [47:41] zero
  output logic      [rrbt_pkg::M_DATA_W-1:0] m_tdata,
  // [2:0] event_res
  output logic      [2:0]                    m_tuser
);

  rrbt_pkg::cfg_t cfg;

  rrbt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register
  logic                          in_valid;
  rrbt_pkg::cmd_t                in_cmd;
  logic [rrbt_pkg::ID_W-1:0]     in_id;
  logic                          in_coord;
  logic                          in_prim;
  logic                          in_sec;

  // request state
  logic                          busy;
  logic [rrbt_pkg::ID_W-1:0]     active_id;
  logic                          active_is_coord;
  logic [rrbt_pkg::CNT_W-1:0]    retry_count;
  logic [31:0]                   elapsed_count;
  logic [31:0]                   current_wait;
  logic [31:0]                   wait_left;
  logic                          addr_parity;
  logic                          start_toggle;

  // result register
  rrbt_pkg::event_t              res_event;
  logic                          res_idx;
  logic [rrbt_pkg::CNT_W-1:0]    res_count;
  logic [31:0]                   res_ticks;

  logic                          pipe_en;
  logic                          fire;

  assign pipe_en  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || pipe_en;
  assign fire     = in_valid && pipe_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd   <= rrbt_pkg::cmd_t'(s_tuser);
      in_id    <= s_tdata[63:0];
      in_coord <= s_tdata[64];
      in_prim  <= s_tdata[65];
      in_sec   <= s_tdata[66];
    end
  end

  // next-state logic
  logic                          is_start;
  logic                          is_tick;
  logic                          eff_coord;
  logic [rrbt_pkg::CNT_W-1:0]    base_rc;
  logic [31:0]                   base_el;
  logic [31:0]                   base_cw;
  logic                          base_par;
  logic                          do_attempt;
  logic [31:0]                   sel_init;
  logic [31:0]                   sel_cap;
  logic [31:0]                   sel_dl;
  logic [rrbt_pkg::CNT_W-1:0]    rc_inc;
  logic                          timed_out;
  logic                          pick_ok;
  logic                          pick;
  logic [32:0]                   grown;
  logic [31:0]                   wait_new;

  logic                          busy_next;
  logic [rrbt_pkg::ID_W-1:0]     active_id_next;
  logic                          active_is_coord_next;
  logic [rrbt_pkg::CNT_W-1:0]    retry_count_next;
  logic [31:0]                   elapsed_count_next;
  logic [31:0]                   current_wait_next;
  logic [31:0]                   wait_left_next;
  logic                          addr_parity_next;
  logic                          start_toggle_next;
  rrbt_pkg::event_t              res_event_next;
  logic                          res_idx_next;

  assign is_start  = (in_cmd == rrbt_pkg::CMD_START);
  assign is_tick   = (in_cmd == rrbt_pkg::CMD_TICK);
  assign eff_coord = is_start ? in_coord : active_is_coord;
  assign base_rc   = is_start ? '0 : retry_count;
  assign base_par  = is_start ? start_toggle : addr_parity;
  assign base_cw   = is_start ? '0 : current_wait;

  always_comb begin
    if (is_start) begin
      base_el = '0;
    end else if (is_tick && busy && elapsed_count != 32'hFFFF_FFFF) begin
      base_el = elapsed_count + 32'd1;
    end else begin
      base_el = elapsed_count;
    end
  end

  assign do_attempt = is_start || (is_tick && busy && wait_left <= 32'd1);

  assign sel_init  = eff_coord ? cfg.coord_initial_wait : cfg.shard_initial_wait;
  assign sel_cap   = eff_coord ? cfg.coord_max_wait     : cfg.shard_max_wait;
  assign sel_dl    = eff_coord ? cfg.coord_deadline     : cfg.shard_deadline;

  assign rc_inc    = (base_rc == '1) ? base_rc : base_rc + 1'b1;
  assign timed_out = base_el > sel_dl;
  assign pick_ok   = base_par ? in_sec : in_prim;
  assign pick      = pick_ok ? base_par : 1'b0;
  // floor(3w/2) = w + floor(w/2)
  assign grown     = {1'b0, base_cw} + {2'b00, base_cw[31:1]};

  always_comb begin
    if (base_cw == '0) begin
      wait_new = sel_init;
    end else if (grown < {1'b0, sel_cap}) begin
      wait_new = grown[31:0];
    end else begin
      wait_new = sel_cap;
    end
  end

  always_comb begin
    busy_next            = busy;
    active_id_next       = active_id;
    active_is_coord_next = active_is_coord;
    retry_count_next     = base_rc;
    elapsed_count_next   = base_el;
    current_wait_next    = base_cw;
    wait_left_next       = is_start ? '0 : wait_left;
    addr_parity_next     = base_par;
    start_toggle_next    = start_toggle;
    res_event_next       = rrbt_pkg::EV_NOTHING;
    res_idx_next         = 1'b0;

    case (in_cmd)
      rrbt_pkg::CMD_START: begin
        busy_next            = 1'b1;
        active_id_next       = in_id;
        active_is_coord_next = in_coord;
        start_toggle_next    = ~start_toggle;
      end
      rrbt_pkg::CMD_TICK: begin
        if (busy && wait_left > 32'd1) begin
          wait_left_next = wait_left - 32'd1;
        end else if (busy) begin
          wait_left_next = '0;
        end
      end
      rrbt_pkg::CMD_RESP: begin
        if (busy && in_id == active_id) begin
          busy_next      = 1'b0;
          res_event_next = rrbt_pkg::EV_DONE;
        end else begin
          res_event_next = rrbt_pkg::EV_DROPPED;
        end
      end
      default: ;
    endcase

    if (do_attempt) begin
      retry_count_next = rc_inc;
      if (timed_out) begin
        busy_next      = 1'b0;
        res_event_next = rrbt_pkg::EV_TIMEOUT;
      end else if (!pick_ok && !in_prim) begin
        busy_next      = 1'b0;
        res_event_next = rrbt_pkg::EV_NOADDR;
      end else begin
        addr_parity_next  = ~base_par;
        current_wait_next = wait_new;
        wait_left_next    = wait_new;
        res_event_next    = rrbt_pkg::EV_SEND;
        res_idx_next      = pick;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy            <= 1'b0;
      active_id       <= '0;
      active_is_coord <= 1'b0;
      retry_count     <= '0;
      elapsed_count   <= '0;
      current_wait    <= '0;
      wait_left       <= '0;
      addr_parity     <= 1'b0;
      start_toggle    <= 1'b0;
    end else if (fire) begin
      busy            <= busy_next;
      active_id       <= active_id_next;
      active_is_coord <= active_is_coord_next;
      retry_count     <= retry_count_next;
      elapsed_count   <= elapsed_count_next;
      current_wait    <= current_wait_next;
      wait_left       <= wait_left_next;
      addr_parity     <= addr_parity_next;
      start_toggle    <= start_toggle_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pipe_en) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_event <= res_event_next;
      res_idx   <= res_idx_next;
      res_count <= retry_count_next;
      res_ticks <= elapsed_count_next;
    end
  end

  assign m_tuser = res_event;
  assign m_tdata = {7'd0, res_ticks, res_count, res_idx};

`ifndef SYNTHESIS
  a_send_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res_event == rrbt_pkg::EV_SEND) |-> busy)
    else $error("send reported while idle");

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (res_event == rrbt_pkg::EV_DONE || res_event == rrbt_pkg::EV_TIMEOUT
      || res_event == rrbt_pkg::EV_NOADDR)) |-> !busy)
    else $error("request ended but still busy");

  a_wait_bound: assert property (@(posedge clk) disable iff (rst)
    wait_left <= current_wait)
    else $error("wait_left above current_wait");

  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    (fire && in_cmd == rrbt_pkg::CMD_TICK && !busy) |=>
      (res_event == rrbt_pkg::EV_NOTHING && $stable(elapsed_count)))
    else $error("idle tick changed state");

  a_send_counted: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res_event == rrbt_pkg::EV_SEND) |-> res_count != '0)
    else $error("send without attempt count");
`endif

endmodule

`default_nettype wire
